// File: rtl/qcp_pkg.sv
`timescale 1ns / 1ps
package qcp_pkg;

  localparam int unsigned BitsPerAxisDef = 8;
  localparam int unsigned MaxBitsPerAxis = 16;
  localparam int unsigned CoordW = 14;
  localparam int unsigned LevelW = 4;
  localparam int unsigned IndexW = 16;

  localparam logic [IndexW-1:0] MaskXBits = 16'h5555;
  localparam logic [IndexW-1:0] MaskZBits = 16'haaaa;

  localparam logic [4:0] WorldLog2Reset = 5'd16;
  localparam logic [3:0] LevelsReset = 4'd5;

  typedef enum logic {
    RegWorldLog2 = 1'b0,
    RegLevels    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } box_t;

  typedef struct packed {
    logic [LevelW-1:0] tree_level;
    logic [IndexW-1:0] cell_index;
  } result_t;

  typedef struct packed {
    logic [4:0] world_log2;
    logic [3:0] levels;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               ext_big;
    logic               ext_pos;
    logic [30:0]        ext_mag;
    logic signed [33:0] nx;
    logic signed [33:0] nz;
  } span_t;

  typedef struct packed {
    logic               valid;
    logic [LevelW-1:0]  level;
    logic signed [33:0] nx;
    logic signed [33:0] nz;
  } lvl_t;

endpackage

// File: rtl/qcp_apb_regs.sv
`timescale 1ns / 1ps
module qcp_apb_regs import qcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [4:0] world_log2_q, world_log2_d;
  logic [3:0] levels_q, levels_d;
  logic       wr_en;
  reg_idx_e   sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = reg_idx_e'(paddr[2]);

  always_comb begin
    world_log2_d = world_log2_q;
    levels_d     = levels_q;
    if (wr_en) begin
      unique case (sel)
        RegWorldLog2: world_log2_d = pwdata[4:0];
        RegLevels:    levels_d     = pwdata[3:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_log2_q <= WorldLog2Reset;
      levels_q     <= LevelsReset;
    end else begin
      world_log2_q <= world_log2_d;
      levels_q     <= levels_d;
    end
  end

  always_comb begin
    unique case (sel)
      RegWorldLog2: prdata = {27'd0, world_log2_q};
      RegLevels:    prdata = {28'd0, levels_q};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o.world_log2 = world_log2_q;
  assign cfg_o.levels     = levels_q;

endmodule

// File: rtl/qcp_span_stage.sv
`timescale 1ns / 1ps
module qcp_span_stage import qcp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  box_t  box_i,
  input  cfg_t  cfg_i,
  output span_t span_o
);

  logic               s1_valid_q;
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [32:0] dx_d, dy_d, dz_d;
  logic signed [33:0] nx_q, nz_q, nx_d, nz_d;
  logic signed [33:0] size_s;
  logic [31:0]        size;

  logic signed [32:0] extent;
  logic               s2_valid_q;
  logic               ext_big_q, ext_big_d;
  logic               ext_pos_q, ext_pos_d;
  logic [30:0]        ext_mag_q;
  logic signed [33:0] nx2_q, nz2_q;

  assign size   = 32'd1 << cfg_i.world_log2;
  assign size_s = $signed({2'b00, size});

  always_comb begin
    dx_d = 33'(box_i.box_max_x) - 33'(box_i.box_min_x);
    dy_d = 33'(box_i.box_max_y) - 33'(box_i.box_min_y);
    dz_d = 33'(box_i.box_max_z) - 33'(box_i.box_min_z);
    nx_d = 34'(box_i.box_min_x) + 34'(box_i.box_max_x) + size_s;
    nz_d = 34'(box_i.box_min_z) + 34'(box_i.box_max_z) + size_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
    dz_q <= dz_d;
    nx_q <= nx_d;
    nz_q <= nz_d;
  end

  always_comb begin
    extent = dz_q;
    if (dy_q > extent) extent = dy_q;
    if (dx_q > extent) extent = dx_q;
    ext_big_d = 34'(extent) >= size_s;
    ext_pos_d = extent > 33'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ext_big_q <= ext_big_d;
    ext_pos_q <= ext_pos_d;
    ext_mag_q <= extent[30:0];
    nx2_q     <= nx_q;
    nz2_q     <= nz_q;
  end

  assign span_o.valid   = s2_valid_q;
  assign span_o.ext_big = ext_big_q;
  assign span_o.ext_pos = ext_pos_q;
  assign span_o.ext_mag = ext_mag_q;
  assign span_o.nx      = nx2_q;
  assign span_o.nz      = nz2_q;

endmodule

// File: rtl/qcp_level_stage.sv
`timescale 1ns / 1ps
module qcp_level_stage import qcp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  span_t span_i,
  input  cfg_t  cfg_i,
  output lvl_t  lvl_o
);

  logic [4:0]        msb;
  logic [4:0]        depth;
  logic [3:0]        lev_cap;
  logic [LevelW-1:0] level_d, level_q;
  logic              valid_q;
  logic signed [33:0] nx_q, nz_q;

  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (span_i.ext_mag[i]) msb = 5'(i);
    end
  end

  assign depth   = cfg_i.world_log2 - msb;
  assign lev_cap = (cfg_i.levels == 4'd0) ? 4'd0 : cfg_i.levels - 4'd1;

  always_comb begin
    priority if (span_i.ext_big || lev_cap == 4'd0) begin
      level_d = '0;
    end else if (!span_i.ext_pos) begin
      level_d = lev_cap;
    end else if (depth > {1'b0, lev_cap}) begin
      level_d = lev_cap;
    end else begin
      level_d = depth[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= span_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    nx_q    <= span_i.nx;
    nz_q    <= span_i.nz;
  end

  assign lvl_o.valid = valid_q;
  assign lvl_o.level = level_q;
  assign lvl_o.nx    = nx_q;
  assign lvl_o.nz    = nz_q;

endmodule

// File: rtl/qcp_coord_clamp.sv
`timescale 1ns / 1ps
module qcp_coord_clamp import qcp_pkg::*; (
  input  logic signed [33:0]         n_i,
  input  logic [LevelW-1:0]          level_i,
  input  logic [4:0]                 world_log2_i,
  output logic [MaxBitsPerAxis-1:0]  coord_o
);

  logic signed [6:0] e;
  logic [6:0]        k;
  logic              pos;
  logic [14:0]       maxc_w;
  logic [CoordW-1:0] maxc;
  logic [32:0]       rsh;
  logic [26:0]       lsh;
  logic              sat;
  logic [CoordW-1:0] c;

  assign e      = $signed({2'b00, world_log2_i}) - $signed({3'b000, level_i}) + 7'sd1;
  assign k      = 7'd0 - e;
  assign pos    = !n_i[33] && (n_i != 34'sd0);
  assign maxc_w = (15'd1 << level_i) - 15'd1;
  assign maxc   = maxc_w[CoordW-1:0];
  assign rsh    = n_i[32:0] >> e[5:0];
  assign lsh    = {13'd0, n_i[13:0]} << k[3:0];

  always_comb begin
    if (!e[6]) begin
      sat = rsh > {19'd0, maxc};
      c   = rsh[CoordW-1:0];
    end else begin
      sat = (n_i[32:14] != 19'd0) || (lsh > {13'd0, maxc});
      c   = lsh[CoordW-1:0];
    end
  end

  always_comb begin
    priority if (!pos) begin
      coord_o = '0;
    end else if (sat) begin
      coord_o = MaxBitsPerAxis'(maxc);
    end else begin
      coord_o = MaxBitsPerAxis'(c);
    end
  end

endmodule

// File: rtl/quadtree_cell_placement_core.sv
`timescale 1ns / 1ps
// Quadtree cell placement core.
// A box beat is taken on the box_i port at a rising edge where start is high
// and busy is low. busy stays low, so a new box may be issued every cycle.
// Each box gives one result: tree_level and cell_index on result_o, marked by
// done_o for exactly one cycle. After its box is taken, a result passes span
// and extent in two register stages, the level in one, the cell clamp in one,
// and the Morton interleave lands in the output register.
// Throughput is one box per cycle at every stage.
// The receiver cannot stall; every result must be taken in its strobe cycle.
// Configuration is written over the APB port at byte addresses 0 (world size
// log2) and 4 (levels in use); the user must write it only while no box is
// in flight, which the block does not enforce; pready is always high. Reset
// clears pipeline valid bits; defaults: world size log2 sixteen, levels five.
module quadtree_cell_placement_core import qcp_pkg::*; #(
  parameter int unsigned BitsPerAxis = BitsPerAxisDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  box_t        box_i,
  output logic        done_o,
  output result_t     result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NSpread = (BitsPerAxis < 8) ? BitsPerAxis : 8;

  cfg_t  cfg;
  span_t span;
  lvl_t  lvl;
  logic  accept;

  logic [MaxBitsPerAxis-1:0] cx_full, cz_full;
  logic                      s4_valid_q;
  logic [LevelW-1:0]         s4_level_q;
  logic [BitsPerAxis-1:0]    cx_q, cz_q;

  logic [IndexW-1:0] spread_x, spread_z;
  logic              done_q;
  result_t           result_q, result_d;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  qcp_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  qcp_span_stage u_span (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .box_i  (box_i),
    .cfg_i  (cfg),
    .span_o (span)
  );

  qcp_level_stage u_level (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .span_i(span),
    .cfg_i (cfg),
    .lvl_o (lvl)
  );

  qcp_coord_clamp u_clamp_x (
    .n_i         (lvl.nx),
    .level_i     (lvl.level),
    .world_log2_i(cfg.world_log2),
    .coord_o     (cx_full)
  );

  qcp_coord_clamp u_clamp_z (
    .n_i         (lvl.nz),
    .level_i     (lvl.level),
    .world_log2_i(cfg.world_log2),
    .coord_o     (cz_full)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s4_valid_q <= lvl.valid;
      done_q     <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_level_q <= lvl.level;
    cx_q       <= cx_full[BitsPerAxis-1:0];
    cz_q       <= cz_full[BitsPerAxis-1:0];
    result_q   <= result_d;
  end

  always_comb begin
    spread_x = '0;
    spread_z = '0;
    for (int i = 0; i < NSpread; i++) begin
      spread_x[2*i]   = cx_q[i];
      spread_z[2*i+1] = cz_q[i];
    end
    result_d.tree_level = s4_level_q;
    result_d.cell_index = (spread_x & MaskXBits) | (spread_z & MaskZBits);
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 done_o)
    else $error("box beat did not produce a result after five cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.tree_level == '0) || (result_o.tree_level < cfg.levels))
    else $error("tree level beyond the levels in use");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.tree_level < 4'd8)
      |-> ((result_o.cell_index >> {result_o.tree_level, 1'b0}) == '0))
    else $error("cell index outside its level");

endmodule
